// ----- rtl/e2q_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package e2q_pkg;

    // Result width, Q1.(OUT_WIDTH-1); valid from 10 to 32
    localparam int OUT_WIDTH = 16;

    localparam int ANGLE_W = 16;
    localparam int MAG_W   = 31;   // Q30 magnitude up to and including 1.0
    localparam int PROD_W  = 62;

    localparam logic [MAG_W-1:0]  Q30_ONE   = 31'h4000_0000;
    localparam logic [PROD_W-1:0] PROD_HALF = 62'd1 << 29;

    // Half angle in 1/256 degree
    localparam logic [16:0] LIM_45  = 17'd11520;
    localparam logic [16:0] LIM_90  = 17'd23040;
    localparam logic [16:0] LIM_180 = 17'd46080;

    // Radians per half-angle unit, Q32
    localparam logic [18:0] RAD_K = 19'd292818;

    // Series terms; each constant divide is a multiply by ceil(2^SH/div)
    localparam int N_TERMS = 4;
    localparam int unsigned SIN_SH [N_TERMS] = '{38, 37, 36, 34};
    localparam int unsigned COS_SH [N_TERMS] = '{38, 37, 36, 35};
    localparam logic [31:0] SIN_RCP [N_TERMS] = '{
        32'(((64'd1 << 38) + 64'd71) / 64'd72),
        32'(((64'd1 << 37) + 64'd41) / 64'd42),
        32'(((64'd1 << 36) + 64'd19) / 64'd20),
        32'(((64'd1 << 34) + 64'd5) / 64'd6)
    };
    localparam logic [31:0] COS_RCP [N_TERMS] = '{
        32'(((64'd1 << 38) + 64'd89) / 64'd90),
        32'(((64'd1 << 37) + 64'd55) / 64'd56),
        32'(((64'd1 << 36) + 64'd29) / 64'd30),
        32'(((64'd1 << 35) + 64'd11) / 64'd12)
    };

    // Output scaling and saturation
    localparam int ROUND_SH = 31 - OUT_WIDTH;
    localparam int RND_W    = 34;
    localparam logic [RND_W-1:0] SAT_POS = RND_W'((64'd1 << (OUT_WIDTH - 1)) - 64'd1);
    localparam logic [RND_W-1:0] SAT_NEG = RND_W'(64'd1 << (OUT_WIDTH - 1));

    localparam int TRIG_LAT = 20;
    localparam int QUAT_LAT = 9;
    localparam int PIPE_LAT = TRIG_LAT + QUAT_LAT;

    typedef logic signed [ANGLE_W-1:0]   t_angle;
    typedef logic signed [OUT_WIDTH-1:0] t_comp;

    typedef struct packed {
        logic             sn_neg;
        logic [MAG_W-1:0] sn_mag;
        logic             cs_neg;
        logic [MAG_W-1:0] cs_mag;
    } t_trig;

    typedef struct packed {
        t_comp w;
        t_comp x;
        t_comp y;
        t_comp z;
    } t_quat;

endpackage

`default_nettype wire

// ----- rtl/e2q_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface e2q_in_if;
    import e2q_pkg::*;

    logic   valid;
    logic   ready;
    t_angle roll_angle;
    t_angle pitch_angle;
    t_angle yaw_angle;

    modport source (output valid, output roll_angle, output pitch_angle, output yaw_angle,
                    input ready);
    modport sink   (input valid, input roll_angle, input pitch_angle, input yaw_angle,
                    output ready);
endinterface

interface e2q_out_if;
    import e2q_pkg::*;

    logic  valid;
    logic  ready;
    t_comp w_component;
    t_comp x_component;
    t_comp y_component;
    t_comp z_component;

    modport source (output valid, output w_component, output x_component,
                    output y_component, output z_component, input ready);
    modport sink   (input valid, input w_component, input x_component,
                    input y_component, input z_component, output ready);
endinterface

`default_nettype wire

// ----- rtl/euler_to_quaternion.sv -----
// ZYX Euler angles to unit quaternion.
//
// Input channel i_angles carries roll, pitch and yaw, signed, 1/128 degree.
// Output channel o_quat carries w, x, y, z as signed Q1.15; +1.0 reads 32767.
// Both channels use valid/ready; a beat moves when both are high.
//
// Throughput is one beat per cycle while the output is not stalled. From accept
// to result valid: 20 stages of half-angle sine and cosine (fold, radian scale,
// square, four series terms of multiply / constant divide / subtract, final
// multiply, unfold) and 9 stages of pair and triple products, sums,
// rounding and saturation. No stage chains more than one multiply.
//
// The whole pipeline advances together. When the receiver holds ready low
// with a result waiting, every stage holds and i_angles.ready drops; no beat
// is lost or repeated. Bubbles between beats are carried as cleared valid
// bits. Reset clears the valid bits only; no other state is kept.
`timescale 1ns / 1ps
`default_nettype none

module euler_to_quaternion (
    input  logic      i_clk,
    input  logic      i_rst_n,
    e2q_in_if.sink    i_angles,
    e2q_out_if.source o_quat
);
    import e2q_pkg::*;

    logic                en;
    logic [PIPE_LAT-1:0] r_vld;
    t_trig               roll_trig;
    t_trig               pitch_trig;
    t_trig               yaw_trig;
    t_quat               quat;

    // Advance while the output register is empty or being drained
    assign en             = !r_vld[PIPE_LAT-1] || o_quat.ready;
    assign i_angles.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[PIPE_LAT-2:0], i_angles.valid};
        end
    end

    e2q_trig u_roll (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (i_angles.roll_angle),
        .o_trig  (roll_trig)
    );

    e2q_trig u_pitch (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (i_angles.pitch_angle),
        .o_trig  (pitch_trig)
    );

    e2q_trig u_yaw (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (i_angles.yaw_angle),
        .o_trig  (yaw_trig)
    );

    e2q_quat u_quat (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_roll  (roll_trig),
        .i_pitch (pitch_trig),
        .i_yaw   (yaw_trig),
        .o_quat  (quat)
    );

    assign o_quat.valid       = r_vld[PIPE_LAT-1];
    assign o_quat.w_component = quat.w;
    assign o_quat.x_component = quat.x;
    assign o_quat.y_component = quat.y;
    assign o_quat.z_component = quat.z;

endmodule

`default_nettype wire

// ----- rtl/e2q_trig.sv -----
`timescale 1ns / 1ps
`default_nettype none

module e2q_trig (
    input  logic           i_clk,
    input  logic           i_en,
    input  e2q_pkg::t_angle i_angle,
    output e2q_pkg::t_trig  o_trig
);
    import e2q_pkg::*;

    typedef struct packed {
        logic s_neg;
        logic c_neg;
        logic swap;
    } t_fold;

    localparam int X_DEPTH  = 15;
    localparam int X2_DEPTH = 13;
    localparam int F_DEPTH  = TRIG_LAT - 1;

    logic [16:0] n_abs;
    logic [16:0] n_fold1;
    logic [13:0] n_m;
    t_fold       n_fold;

    logic [13:0]       r_m;
    logic [32:0]       r_xm;
    logic [29:0]       r_x_d  [X_DEPTH];
    logic [59:0]       r_xx;
    logic [29:0]       r_x2_d [X2_DEPTH];
    t_fold             r_f_d  [F_DEPTH];

    logic [MAG_W-1:0]  s_tin [N_TERMS];
    logic [MAG_W-1:0]  c_tin [N_TERMS];
    logic [60:0]       r_sp  [N_TERMS];
    logic [60:0]       r_cp  [N_TERMS];
    logic [62:0]       r_sd  [N_TERMS];
    logic [62:0]       r_cd  [N_TERMS];
    logic [MAG_W-1:0]  r_st  [N_TERMS];
    logic [MAG_W-1:0]  r_ct  [N_TERMS];

    logic [60:0]       r_sfp;
    logic [60:0]       r_cfp;
    logic [MAG_W-1:0]  r_sv;
    logic [MAG_W-1:0]  r_cv;
    t_trig             r_out;

    // Fold the half angle into [0, 45] degrees
    always_comb begin
        n_abs        = i_angle[ANGLE_W-1] ? (17'd0 - {1'b1, i_angle}) : {1'b0, i_angle};
        n_fold.s_neg = i_angle[ANGLE_W-1];
        n_fold.c_neg = n_abs > LIM_90;
        n_fold1      = n_fold.c_neg ? (LIM_180 - n_abs) : n_abs;
        n_fold.swap  = n_fold1 > LIM_45;
        n_m          = n_fold.swap ? 14'(LIM_90 - n_fold1) : 14'(n_fold1);
    end

    // Horner input of each term: the first starts from one
    always_comb begin
        s_tin[0] = Q30_ONE;
        c_tin[0] = Q30_ONE;
        for (int k = 1; k < N_TERMS; k++) begin
            s_tin[k] = r_st[k-1];
            c_tin[k] = r_ct[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m      <= n_m;
            r_f_d[0] <= n_fold;
            for (int i = 1; i < F_DEPTH; i++) begin
                r_f_d[i] <= r_f_d[i-1];
            end

            r_xm      <= 33'(r_m) * 33'(RAD_K);
            r_x_d[0]  <= 30'((r_xm + 33'd2) >> 2);
            for (int i = 1; i < X_DEPTH; i++) begin
                r_x_d[i] <= r_x_d[i-1];
            end

            r_xx      <= 60'(r_x_d[0]) * 60'(r_x_d[0]);
            r_x2_d[0] <= 30'((62'(r_xx) + PROD_HALF) >> 30);
            for (int i = 1; i < X2_DEPTH; i++) begin
                r_x2_d[i] <= r_x2_d[i-1];
            end

            // Each term: multiply by x^2, divide by constant, subtract from one
            for (int k = 0; k < N_TERMS; k++) begin
                r_sp[k] <= 61'(r_x2_d[3*k]) * 61'(s_tin[k]);
                r_cp[k] <= 61'(r_x2_d[3*k]) * 61'(c_tin[k]);
                r_sd[k] <= 63'(r_sp[k][60:30]) * 63'(SIN_RCP[k]);
                r_cd[k] <= 63'(r_cp[k][60:30]) * 63'(COS_RCP[k]);
                r_st[k] <= Q30_ONE - 31'(r_sd[k] >> SIN_SH[k]);
                r_ct[k] <= Q30_ONE - 31'(r_cd[k] >> COS_SH[k]);
            end

            r_sfp <= 61'(r_x_d[X_DEPTH-1]) * 61'(r_st[N_TERMS-1]);
            r_cfp <= 61'(r_x2_d[X2_DEPTH-1]) * 61'(r_ct[N_TERMS-1]);
            r_sv  <= r_sfp[60:30];
            r_cv  <= Q30_ONE - {1'b0, r_cfp[60:31]};

            // Undo the fold: swap first, then signs
            r_out.sn_neg <= r_f_d[F_DEPTH-1].s_neg;
            r_out.cs_neg <= r_f_d[F_DEPTH-1].c_neg;
            r_out.sn_mag <= r_f_d[F_DEPTH-1].swap ? r_cv : r_sv;
            r_out.cs_mag <= r_f_d[F_DEPTH-1].swap ? r_sv : r_cv;
        end
    end

    assign o_trig = r_out;

endmodule

`default_nettype wire

// ----- rtl/e2q_quat.sv -----
`timescale 1ns / 1ps
`default_nettype none

module e2q_quat (
    input  logic           i_clk,
    input  logic           i_en,
    input  e2q_pkg::t_trig i_roll,
    input  e2q_pkg::t_trig i_pitch,
    input  e2q_pkg::t_trig i_yaw,
    output e2q_pkg::t_quat o_quat
);
    import e2q_pkg::*;

    // Pairs: cr*cp, sr*sp, sr*cp, cr*sp. Triples pair with yaw so that
    // component c = triple[2c] + triple[2c+1] (minus for x and z).
    localparam int unsigned PAIR_SEL [8] = '{0, 1, 2, 3, 3, 2, 0, 1};
    localparam logic        YAW_SIN  [8] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};

    logic [MAG_W-1:0]  pa_mag [4];
    logic              pa_neg [4];
    logic [MAG_W-1:0]  pb_mag [4];
    logic              pb_neg [4];

    logic [PROD_W-1:0] r_pr_mag [4];
    logic              r_pr_neg [4];
    t_trig             r_y1;
    logic [MAG_W-1:0]  r_pa_mag [4];
    logic              r_pa_neg [4];
    t_trig             r_y2;
    logic [PROD_W-1:0] r_tp_mag [8];
    logic              r_tp_neg [8];
    logic [MAG_W-1:0]  r_tr_mag [8];
    logic              r_tr_neg [8];
    logic signed [31:0] r_tv    [8];
    logic signed [32:0] r_sum   [4];
    logic [31:0]       r_mag    [4];
    logic              r_neg    [4];
    logic [RND_W-1:0]  n_rnd    [4];
    logic [RND_W-1:0]  r_rnd    [4];
    logic              r_neg2   [4];
    logic [RND_W-1:0]  n_sat    [4];
    t_comp             n_comp   [4];
    t_comp             r_comp   [4];

    always_comb begin
        pa_mag[0] = i_roll.cs_mag;  pa_neg[0] = i_roll.cs_neg;
        pb_mag[0] = i_pitch.cs_mag; pb_neg[0] = i_pitch.cs_neg;
        pa_mag[1] = i_roll.sn_mag;  pa_neg[1] = i_roll.sn_neg;
        pb_mag[1] = i_pitch.sn_mag; pb_neg[1] = i_pitch.sn_neg;
        pa_mag[2] = i_roll.sn_mag;  pa_neg[2] = i_roll.sn_neg;
        pb_mag[2] = i_pitch.cs_mag; pb_neg[2] = i_pitch.cs_neg;
        pa_mag[3] = i_roll.cs_mag;  pa_neg[3] = i_roll.cs_neg;
        pb_mag[3] = i_pitch.sn_mag; pb_neg[3] = i_pitch.sn_neg;
    end

    generate
        if (ROUND_SH > 0) begin : g_rnd_down
            always_comb begin
                for (int c = 0; c < 4; c++) begin
                    n_rnd[c] = (RND_W'(r_mag[c]) + (RND_W'(1) << (ROUND_SH - 1))) >> ROUND_SH;
                end
            end
        end else if (ROUND_SH == 0) begin : g_rnd_keep
            always_comb begin
                for (int c = 0; c < 4; c++) begin
                    n_rnd[c] = RND_W'(r_mag[c]);
                end
            end
        end else begin : g_rnd_up
            always_comb begin
                for (int c = 0; c < 4; c++) begin
                    n_rnd[c] = RND_W'(r_mag[c]) << (-ROUND_SH);
                end
            end
        end
    endgenerate

    // Saturate on the magnitude; -1.0 is reachable, +1.0 is not
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            if (r_neg2[c]) begin
                n_sat[c]  = (r_rnd[c] > SAT_NEG) ? SAT_NEG : r_rnd[c];
                n_comp[c] = OUT_WIDTH'(RND_W'(0) - n_sat[c]);
            end else begin
                n_sat[c]  = (r_rnd[c] > SAT_POS) ? SAT_POS : r_rnd[c];
                n_comp[c] = OUT_WIDTH'(n_sat[c]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 4; i++) begin
                r_pr_mag[i] <= 62'(pa_mag[i]) * 62'(pb_mag[i]);
                r_pr_neg[i] <= pa_neg[i] ^ pb_neg[i];
                r_pa_mag[i] <= 31'((r_pr_mag[i] + PROD_HALF) >> 30);
                r_pa_neg[i] <= r_pr_neg[i];
            end
            r_y1 <= i_yaw;
            r_y2 <= r_y1;

            for (int j = 0; j < 8; j++) begin
                r_tp_mag[j] <= 62'(r_pa_mag[PAIR_SEL[j]])
                             * 62'(YAW_SIN[j] ? r_y2.sn_mag : r_y2.cs_mag);
                r_tp_neg[j] <= r_pa_neg[PAIR_SEL[j]] ^ (YAW_SIN[j] ? r_y2.sn_neg : r_y2.cs_neg);
                r_tr_mag[j] <= 31'((r_tp_mag[j] + PROD_HALF) >> 30);
                r_tr_neg[j] <= r_tp_neg[j];
                r_tv[j]     <= r_tr_neg[j] ? -$signed({1'b0, r_tr_mag[j]})
                                           : $signed({1'b0, r_tr_mag[j]});
            end

            for (int c = 0; c < 4; c++) begin
                if (c % 2 == 0) begin
                    r_sum[c] <= 33'(r_tv[2*c]) + 33'(r_tv[2*c+1]);
                end else begin
                    r_sum[c] <= 33'(r_tv[2*c]) - 33'(r_tv[2*c+1]);
                end
                r_neg[c]  <= r_sum[c][32];
                r_mag[c]  <= r_sum[c][32] ? 32'(-r_sum[c]) : 32'(r_sum[c]);
                r_rnd[c]  <= n_rnd[c];
                r_neg2[c] <= r_neg[c];
                r_comp[c] <= n_comp[c];
            end
        end
    end

    assign o_quat.w = r_comp[0];
    assign o_quat.x = r_comp[1];
    assign o_quat.y = r_comp[2];
    assign o_quat.z = r_comp[3];

endmodule

`default_nettype wire
